// File: hdl/assert_macros.svh
// Assertion macros shared by the timestamp extender RTL.
// Needs a clk and an arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CTSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CTSE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTSE_ASSERT(lbl, prop, msg)
`define CTSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/ctse_pkg.sv
// Package for the cycle timestamp extender: widths, constants, queue entry,
// divider request/response structs and the back-end state type. No dependencies.
package ctse_pkg;

	localparam int CNT_BITS   = 32;  // width of the free-running counter
	localparam int IN_W       = 32;
	localparam int TOTAL_W    = 64;
	localparam int WRAP_W     = 32;
	localparam int SEC_W      = 45;
	localparam int MS_W       = 10;
	localparam int US_W       = 10;
	localparam int ELAPSED_W  = 32;
	localparam int MHZ_W      = 10;
	localparam int PER_MS_W   = 20;
	localparam int DIV_W      = 30;  // divisor and remainder width
	localparam int STEP_W     = 7;
	localparam int QDEPTH     = 2;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [MHZ_W-1:0]    MHZ_RESET       = MHZ_W'(168);
	localparam logic [PER_MS_W-1:0] MICROS_PER_SEC  = PER_MS_W'(1000000);
	localparam logic [MHZ_W-1:0]    MICROS_PER_MILLI = MHZ_W'(1000);
	localparam logic [MS_W-1:0]     PART_LIMIT      = MS_W'(1000);

	typedef struct packed {
		logic [TOTAL_W-1:0]  total;
		logic [CNT_BITS-1:0] elapsed;
		logic                wrapped;
	} q_entry_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   rem_init;
		logic [TOTAL_W-1:0] num_init;
		logic [DIV_W-1:0]   divisor;
		logic [STEP_W-1:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic [TOTAL_W-1:0] quo;
		logic [DIV_W-1:0]   rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_START,
		B_SEC,
		B_MS,
		B_US,
		B_OUT
	} back_state_t;

endpackage

// File: hdl/ctse_if.sv
// Channel interfaces of the cycle timestamp extender: samples in, timestamps
// out, clock configuration. Depends on ctse_pkg.
interface ctse_in_if;
	import ctse_pkg::*;
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] raw_count;
	logic [IN_W-1:0] earlier_count;
	modport source (output valid, raw_count, earlier_count, input ready);
	modport sink (input valid, raw_count, earlier_count, output ready);
endinterface

interface ctse_out_if;
	import ctse_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [TOTAL_W-1:0]   total_cycles;
	logic [SEC_W-1:0]     whole_seconds;
	logic [MS_W-1:0]      millis_part;
	logic [US_W-1:0]      micros_part;
	logic [ELAPSED_W-1:0] elapsed_cycles;
	logic [ELAPSED_W-1:0] elapsed_micros;
	logic                 wrapped;
	modport source (output valid, total_cycles, whole_seconds, millis_part, micros_part,
		elapsed_cycles, elapsed_micros, wrapped, input ready);
	modport sink (input valid, total_cycles, whole_seconds, millis_part, micros_part,
		elapsed_cycles, elapsed_micros, wrapped, output ready);
endinterface

interface ctse_cfg_if;
	import ctse_pkg::*;
	logic             valid;
	logic             ready;
	logic [MHZ_W-1:0] clock_mhz;
	modport source (output valid, clock_mhz, input ready);
	modport sink (input valid, clock_mhz, output ready);
endinterface

// File: hdl/cycle_timestamp_extender_unit.sv
// Top level of the cycle timestamp extender: configuration register plus
// front end, queue and back end. Depends on ctse_pkg, ctse_if, ctse_front,
// ctse_queue, ctse_back.
//
//   channel     dir   handshake      payload
//   sample_ch   in    valid/ready    raw_count, earlier_count
//   stamp_ch    out   valid/ready    total_cycles .. wrapped
//   cfg_ch      in    valid/ready    clock_mhz (ready always high)
//
// Each item occupies the back end for setup plus one bit per cycle on the
// shared time divider (45 seconds bits, 10 ms bits, 10 us bits), with the
// elapsed division running alongside on its own unit.
// Reset clears the wrap count and last sample and loads 168 MHz.
// A two-entry queue lets samples be taken while the back end is busy or a
// finished timestamp waits in the output register.
module cycle_timestamp_extender_unit (
	input  logic       clk,
	input  logic       arst_n,
	ctse_in_if.sink    sample_ch,
	ctse_out_if.source stamp_ch,
	ctse_cfg_if.sink   cfg_ch
);
	import ctse_pkg::*;

	logic [MHZ_W-1:0] clock_mhz_q;
	logic             q_push, q_pop, q_full, q_empty;
	q_entry_t         q_in, q_head;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clock_mhz_q <= MHZ_RESET;
		else if (cfg_ch.valid)
			clock_mhz_q <= cfg_ch.clock_mhz;
	end

	ctse_front u_front (
		.clk(clk), .arst_n(arst_n), .sample_ch(sample_ch),
		.q_full(q_full), .q_push(q_push), .q_data(q_in)
	);

	ctse_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_in),
		.pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head)
	);

	ctse_back u_back (
		.clk(clk), .arst_n(arst_n), .clock_mhz(clock_mhz_q), .q_empty(q_empty),
		.q_head(q_head), .q_pop(q_pop), .stamp_ch(stamp_ch)
	);

endmodule

// File: hdl/ctse_front.sv
// Front end: accepts counter samples, detects wraps, extends the sample to
// 64 bits and pushes the classified item into the queue. Depends on ctse_pkg.
`include "assert_macros.svh"
module ctse_front (
	input  logic               clk,
	input  logic               arst_n,
	ctse_in_if.sink            sample_ch,
	input  logic               q_full,
	output logic               q_push,
	output ctse_pkg::q_entry_t q_data
);
	import ctse_pkg::*;

	logic [CNT_BITS-1:0] last_sample_q;
	logic [WRAP_W-1:0]   wrap_count_q;
	logic [CNT_BITS-1:0] sample;
	logic [CNT_BITS-1:0] earlier;
	logic                wrap;
	logic [WRAP_W-1:0]   wrap_next;

	assign sample_ch.ready = !q_full;
	assign q_push          = sample_ch.valid && !q_full;
	assign sample          = sample_ch.raw_count[CNT_BITS-1:0];
	assign earlier         = sample_ch.earlier_count[CNT_BITS-1:0];
	assign wrap            = sample < last_sample_q;
	assign wrap_next       = wrap_count_q + WRAP_W'(wrap);

	always_comb begin
		q_data.total   = (TOTAL_W'(wrap_next) << CNT_BITS) + TOTAL_W'(sample);
		q_data.elapsed = sample - earlier;
		q_data.wrapped = wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			wrap_count_q  <= '0;
		end else if (q_push) begin
			last_sample_q <= sample;
			wrap_count_q  <= wrap_next;
		end
	end

	`CTSE_ASSERT(a_wrap_advances, (q_push && wrap) |=> (wrap_count_q == $past(wrap_count_q) + WRAP_W'(1)), "wrap count did not advance on a wrap")
	`CTSE_ASSERT(a_state_holds, !q_push |=> $stable(wrap_count_q) && $stable(last_sample_q), "front state moved without a transaction")

endmodule

// File: hdl/ctse_queue.sv
// Short queue between front and back end; entries shift toward the head slot.
// Depends on ctse_pkg.
`include "assert_macros.svh"
module ctse_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ctse_pkg::q_entry_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output ctse_pkg::q_entry_t head
);
	import ctse_pkg::*;

	q_entry_t            slot_q [QDEPTH];
	logic [QCNT_W-1:0]   count_q;
	logic [QCNT_W-1:0]   wr_pos;

	assign full   = count_q == QCNT_W'(QDEPTH);
	assign empty  = count_q == '0;
	assign head   = slot_q[0];
	assign wr_pos = count_q - QCNT_W'(pop);

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (push && wr_pos == QCNT_W'(i))
				slot_q[i] <= push_data;
			else if (pop && i < QDEPTH - 1)
				slot_q[i] <= slot_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	`CTSE_ASSERT(a_pop_drains, (pop && !push) |=> (count_q == $past(count_q) - QCNT_W'(1)), "pop did not drain the queue")

endmodule

// File: hdl/ctse_div.sv
// Restoring divider, one quotient bit per cycle, with a preloaded partial
// remainder so leading zero quotient bits are skipped. Depends on ctse_pkg.
module ctse_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ctse_pkg::div_req_t req,
	output ctse_pkg::div_rsp_t rsp
);
	import ctse_pkg::*;

	logic [DIV_W-1:0]   rem_q;
	logic [TOTAL_W-1:0] num_q;
	logic [TOTAL_W-1:0] quo_q;
	logic [DIV_W-1:0]   divisor_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [DIV_W:0]     trial;
	logic               fits;

	assign trial = {rem_q, num_q[TOTAL_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_comb begin
		rsp.busy = cnt_q != '0;
		rsp.quo  = quo_q;
		rsp.rem  = rem_q;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.rem_init;
			num_q     <= req.num_init;
			quo_q     <= '0;
			divisor_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, divisor_q}) : trial[DIV_W-1:0];
			num_q <= num_q << 1;
			quo_q <= {quo_q[TOTAL_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

endmodule

// File: hdl/ctse_back.sv
// Back end: pops queued items, splits the total into seconds, milliseconds
// and microseconds on one divider and the elapsed time on a second, then
// holds the timestamp in the output register. Depends on ctse_pkg, ctse_div.
`include "assert_macros.svh"
module ctse_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ctse_pkg::MHZ_W-1:0] clock_mhz,
	input  logic                   q_empty,
	input  ctse_pkg::q_entry_t     q_head,
	output logic                   q_pop,
	ctse_out_if.source             stamp_ch
);
	import ctse_pkg::*;

	back_state_t          state_q, state_d;
	div_req_t             req0, req1;
	div_rsp_t             rsp0, rsp1;

	logic [TOTAL_W-1:0]   total_q;
	logic [CNT_BITS-1:0]  elapsed_q;
	logic                 wrapped_q;
	logic [MHZ_W-1:0]     mhz_q;
	logic [PER_MS_W-1:0]  per_ms_q;
	logic [DIV_W-1:0]     per_sec_q;
	logic [SEC_W-1:0]     secs_q;
	logic [MS_W-1:0]      ms_q;
	logic [US_W-1:0]      us_q;
	logic [ELAPSED_W-1:0] emicros_q;
	logic [MHZ_W-1:0]     mhz_eff;
	logic                 sec_done, ms_done, us_done, out_load;
	logic                 out_valid_q;

	assign mhz_eff = (clock_mhz == '0) ? MHZ_W'(1) : clock_mhz;

	ctse_div u_div_time (.clk(clk), .arst_n(arst_n), .req(req0), .rsp(rsp0));
	ctse_div u_div_elapsed (.clk(clk), .arst_n(arst_n), .req(req1), .rsp(rsp1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		sec_done = 1'b0;
		ms_done  = 1'b0;
		us_done  = 1'b0;
		out_load = 1'b0;
		req0     = '0;
		req1     = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_START;
				end
			end
			B_START: begin
				// seconds: quotient bits above SEC_W are zero, preload the top of the total
				req0.start    = 1'b1;
				req0.rem_init = DIV_W'(total_q >> SEC_W);
				req0.num_init = total_q << (TOTAL_W - SEC_W);
				req0.divisor  = per_sec_q;
				req0.steps    = STEP_W'(SEC_W);
				req1.start    = 1'b1;
				req1.rem_init = '0;
				req1.num_init = TOTAL_W'(elapsed_q) << (TOTAL_W - CNT_BITS);
				req1.divisor  = DIV_W'(mhz_q);
				req1.steps    = STEP_W'(CNT_BITS);
				state_d       = B_SEC;
			end
			B_SEC: begin
				if (!rsp0.busy) begin
					sec_done      = 1'b1;
					req0.start    = 1'b1;
					req0.rem_init = DIV_W'(rsp0.rem >> MS_W);
					req0.num_init = TOTAL_W'(rsp0.rem[MS_W-1:0]) << (TOTAL_W - MS_W);
					req0.divisor  = DIV_W'(per_ms_q);
					req0.steps    = STEP_W'(MS_W);
					state_d       = B_MS;
				end
			end
			B_MS: begin
				if (!rsp0.busy) begin
					ms_done       = 1'b1;
					req0.start    = 1'b1;
					req0.rem_init = DIV_W'(rsp0.rem >> US_W);
					req0.num_init = TOTAL_W'(rsp0.rem[US_W-1:0]) << (TOTAL_W - US_W);
					req0.divisor  = DIV_W'(mhz_q);
					req0.steps    = STEP_W'(US_W);
					state_d       = B_US;
				end
			end
			B_US: begin
				if (!rsp0.busy && !rsp1.busy) begin
					us_done = 1'b1;
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (!out_valid_q || stamp_ch.ready) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			total_q   <= q_head.total;
			elapsed_q <= q_head.elapsed;
			wrapped_q <= q_head.wrapped;
			mhz_q     <= mhz_eff;
			per_ms_q  <= PER_MS_W'(mhz_eff) * PER_MS_W'(MICROS_PER_MILLI);
			per_sec_q <= DIV_W'(mhz_eff) * DIV_W'(MICROS_PER_SEC);
		end
		if (sec_done)
			secs_q <= rsp0.quo[SEC_W-1:0];
		if (ms_done)
			ms_q <= rsp0.quo[MS_W-1:0];
		if (us_done) begin
			us_q      <= rsp0.quo[US_W-1:0];
			emicros_q <= rsp1.quo[ELAPSED_W-1:0];
		end
		if (out_load) begin
			stamp_ch.total_cycles   <= total_q;
			stamp_ch.whole_seconds  <= secs_q;
			stamp_ch.millis_part    <= ms_q;
			stamp_ch.micros_part    <= us_q;
			stamp_ch.elapsed_cycles <= ELAPSED_W'(elapsed_q);
			stamp_ch.elapsed_micros <= emicros_q;
			stamp_ch.wrapped        <= wrapped_q;
		end
	end

	// hold the stamp until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (stamp_ch.ready)
			out_valid_q <= 1'b0;
	end

	assign stamp_ch.valid = out_valid_q;

	`CTSE_ASSERT(a_ms_range, (state_q == B_US) |-> (ms_q < PART_LIMIT), "millisecond part out of range")
	`CTSE_ASSERT(a_idle_pops, (state_q == B_IDLE && !q_empty) |=> (state_q == B_START), "queued item not taken")

endmodule

// File: verif/ctse_stamp_check.sv
// Timestamp checker for cycle_timestamp_extender_unit: watches the sample, stamp and
// clock channels, predicts every stamp and compares it field by field.
// Depends on ctse_pkg and ctse_if.
module ctse_stamp_check (
	input  logic clk,
	input  logic arst_n,
	ctse_in_if   sample_ch,
	ctse_out_if  stamp_ch,
	ctse_cfg_if  cfg_ch,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ctse_pkg::*;

	typedef struct packed {
		logic [TOTAL_W-1:0]   total_cycles;
		logic [SEC_W-1:0]     whole_seconds;
		logic [MS_W-1:0]      millis_part;
		logic [US_W-1:0]      micros_part;
		logic [ELAPSED_W-1:0] elapsed_cycles;
		logic [ELAPSED_W-1:0] elapsed_micros;
		logic                 wrapped;
	} stamp_t;

	logic [MHZ_W-1:0]    clock_setting;
	logic [CNT_BITS-1:0] last_seen;
	logic [WRAP_W-1:0]   wrap_total;
	logic                wrap_now;
	stamp_t              stamps_due[$];
	stamp_t              seen;
	stamp_t              want;
	int                  stamp_idx;

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string field, input logic [63:0] got,
		input logic [63:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("stamp %0d %s: got 0x%0h, expected 0x%0h",
				stamp_idx, field, got, exp_val));
	endtask

	function automatic stamp_t extend_stamp(input logic [CNT_BITS-1:0] raw,
		input logic [CNT_BITS-1:0] earlier, input logic [WRAP_W-1:0] wraps,
		input logic [MHZ_W-1:0] setting, input logic wrap);
		logic [63:0] mhz;
		logic [63:0] per_sec;
		logic [63:0] per_ms;
		logic [63:0] total;
		logic [63:0] rem;
		logic [CNT_BITS-1:0] elapsed;
		stamp_t s;
		// a zero clock counts as 1 MHz
		mhz = (setting == '0) ? 64'd1 : 64'(setting);
		per_sec = mhz * 64'd1000000;
		per_ms = mhz * 64'd1000;
		total = {wraps, raw};
		rem = total % per_sec;
		elapsed = raw - earlier;
		s.total_cycles = total;
		s.whole_seconds = SEC_W'(total / per_sec);
		s.millis_part = MS_W'(rem / per_ms);
		s.micros_part = US_W'((rem % per_ms) / mhz);
		s.elapsed_cycles = elapsed;
		s.elapsed_micros = ELAPSED_W'(64'(elapsed) / mhz);
		s.wrapped = wrap;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_setting = MHZ_RESET;
			last_seen = '0;
			wrap_total = '0;
			stamp_idx = 0;
			errors = 0;
			stamps_due.delete();
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				clock_setting = cfg_ch.clock_mhz;
			if (sample_ch.valid && sample_ch.ready) begin
				wrap_now = sample_ch.raw_count < last_seen;
				if (wrap_now)
					wrap_total = wrap_total + WRAP_W'(1);
				last_seen = sample_ch.raw_count;
				stamps_due.push_back(extend_stamp(sample_ch.raw_count,
					sample_ch.earlier_count, wrap_total, clock_setting, wrap_now));
			end
			if (stamp_ch.valid && stamp_ch.ready) begin
				seen.total_cycles = stamp_ch.total_cycles;
				seen.whole_seconds = stamp_ch.whole_seconds;
				seen.millis_part = stamp_ch.millis_part;
				seen.micros_part = stamp_ch.micros_part;
				seen.elapsed_cycles = stamp_ch.elapsed_cycles;
				seen.elapsed_micros = stamp_ch.elapsed_micros;
				seen.wrapped = stamp_ch.wrapped;
				if (stamps_due.size() == 0) begin
					report_mismatch($sformatf("stamp %0d: unexpected transaction, total 0x%0h",
						stamp_idx, seen.total_cycles));
				end else begin
					want = stamps_due.pop_front();
					check_field("total_cycles", seen.total_cycles, want.total_cycles);
					check_field("whole_seconds", 64'(seen.whole_seconds),
						64'(want.whole_seconds));
					check_field("millis_part", 64'(seen.millis_part), 64'(want.millis_part));
					check_field("micros_part", 64'(seen.micros_part), 64'(want.micros_part));
					check_field("elapsed_cycles", 64'(seen.elapsed_cycles),
						64'(want.elapsed_cycles));
					check_field("elapsed_micros", 64'(seen.elapsed_micros),
						64'(want.elapsed_micros));
					check_field("wrapped", 64'(seen.wrapped), 64'(want.wrapped));
				end
				stamp_idx++;
			end
		end
		pending <= stamps_due.size();
	end

endmodule

// File: verif/tb_top.sv
// Testbench top for cycle_timestamp_extender_unit: clock, reset, sample and clock
// stimulus, output back-pressure, watchdog and verdict.
// Depends on ctse_pkg, ctse_if, the block and ctse_stamp_check.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ctse_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   check_errors;
	int   due_count;
	int   quiet_cycles = 0;
	logic recv_ready_q = 1'b0;
	logic [IN_W-1:0] cursor;

	ctse_in_if  sample_ch();
	ctse_out_if stamp_ch();
	ctse_cfg_if cfg_ch();

	cycle_timestamp_extender_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.stamp_ch  (stamp_ch),
		.cfg_ch    (cfg_ch)
	);

	ctse_stamp_check stamp_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.stamp_ch  (stamp_ch),
		.cfg_ch    (cfg_ch),
		.errors    (check_errors),
		.pending   (due_count)
	);

	always #4 clk = ~clk;

	assign stamp_ch.ready = recv_ready_q;

	always @(posedge clk) begin
		recv_ready_q <= ($urandom_range(99) >= recv_idle_pct);
	end

	// end the run if no channel moves a transaction for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (stamp_ch.valid && stamp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_sample(input logic [IN_W-1:0] raw, input logic [IN_W-1:0] earlier);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_count <= raw;
		sample_ch.earlier_count <= earlier;
		cursor = raw;
		do @(negedge clk); while (!sample_ch.ready);
		@(posedge clk);
	endtask

	task automatic drain_stamps();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (due_count != 0);
		@(posedge clk);
	endtask

	// change the clock only with no stamp in flight
	task automatic set_clock(input logic [MHZ_W-1:0] mhz);
		drain_stamps();
		cfg_ch.valid <= 1'b1;
		cfg_ch.clock_mhz <= mhz;
		do @(negedge clk); while (!cfg_ch.ready);
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly a counter moving forward, with repeats, back steps and noise
	task automatic send_burst(input int count);
		logic [IN_W-1:0] raw;
		logic [IN_W-1:0] earlier;
		int kind;
		repeat (count) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				case ($urandom_range(2))
					0: raw = cursor + $urandom_range(1, 1000);
					1: raw = cursor + $urandom_range(0, 32'h00FF_FFFF);
					default: raw = cursor + $urandom();
				endcase
			end else if (kind < 80) begin
				raw = cursor;
			end else if (kind < 90) begin
				raw = (cursor == '0) ? $urandom() : $urandom_range(0, cursor - 1);
			end else begin
				raw = $urandom();
			end
			if ($urandom_range(3) == 0)
				earlier = $urandom();
			else
				earlier = raw - $urandom_range(0, 32'h000F_FFFF);
			send_sample(raw, earlier);
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct);
		logic [MHZ_W-1:0] mhz;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (5) begin
			case ($urandom_range(9))
				0: mhz = '0;
				1: mhz = MHZ_W'(1);
				2: mhz = '1;
				3: mhz = MHZ_W'(1000);
				default: mhz = MHZ_W'($urandom_range(1, 1023));
			endcase
			set_clock(mhz);
			send_burst(50);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cursor = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_count = '0;
		sample_ch.earlier_count = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.clock_mhz = MHZ_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset clock: equal samples, field extremes, wraps, elapsed wrapping below zero
		send_sample(32'h0000_0000, 32'h0000_0000);
		send_sample(32'hFFFF_FFFF, 32'h0000_0000);
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h0000_0000, 32'hFFFF_FFFF);
		send_sample(32'h0000_0001, 32'h0000_0002);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'h5555_5555, 32'hAAAA_AAAA);
		send_sample(32'hAAAA_AAAA, 32'h5555_5555);

		// zero clock counts as 1 MHz
		set_clock('0);
		send_sample(32'hFFFF_FFFF, 32'h0000_0000);
		send_sample(32'h0000_0064, 32'h0000_0000);
		send_sample(32'hFFFF_FFFE, 32'h0000_0001);

		set_clock('1);
		send_sample(32'hFFFF_FFFF, 32'h0000_0000);
		send_sample(32'h0000_03FE, 32'h0000_03FF);
		send_sample(32'h0000_03FF, 32'h0000_0000);

		set_clock(MHZ_W'(1));
		send_sample(32'h0000_0000, 32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFF, 32'h0000_0000);

		set_clock(MHZ_W'(1000));
		send_sample(32'h3B9A_C9FF, 32'h0000_0000);
		send_sample(32'h3B9A_CA00, 32'h0000_03E8);

		run_phase(12, 55);
		run_phase(55, 12);
		run_phase(0, 0);

		drain_stamps();
		repeat (80) @(posedge clk);
		if (check_errors == 0 && due_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ctse_pkg.sv
hdl/ctse_if.sv
hdl/ctse_front.sv
hdl/ctse_queue.sv
hdl/ctse_div.sv
hdl/ctse_back.sv
hdl/cycle_timestamp_extender_unit.sv
verif/ctse_stamp_check.sv
verif/tb_top.sv
